@@ rtl/core/sktl_pkg.sv @@
package sktl_pkg;

  localparam int LIST_DEPTH_DEF = 16;
  localparam int ID_BITS_DEF    = 16;
  localparam int KEY_BITS_DEF   = 16;
  localparam int DIR_BITS       = 3;
  localparam int REQ_BITS       = 2;
  localparam int COUNT_BITS     = 5;

  typedef enum logic [REQ_BITS-1:0] {
    REQ_ADD    = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_QUERY  = 2'd2
  } req_t;

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_FIND = 7'b0000010,
    ST_DEL  = 7'b0000100,
    ST_SEEK = 7'b0001000,
    ST_INS  = 7'b0010000,
    ST_PUT  = 7'b0100000,
    ST_DONE = 7'b1000000
  } state_t;

endpackage

@@ rtl/core/sorted_keyed_tile_list_core.sv @@
// Sorted list of up to LIST_DEPTH entries (id, key, direction), packed from slot 0 in
// ascending key order, equal keys in arrival order. Ops: add (replaces an entry with the
// same id, dropped when full and the id is absent), remove by id, query by id. Entries
// live in one single-port-read, single-port-write RAM walked by a small sequencer:
// query scans the slots for the id, remove also closes the gap the entry leaves, and an
// add does both, then scans again to find its place and opens the gap. One operation
// at a time; in_stall stays high until its result has gone into the output register,
// which holds it until taken while the next operation may already be accepted.
module sorted_keyed_tile_list_core #(
  parameter int LIST_DEPTH = sktl_pkg::LIST_DEPTH_DEF,
  parameter int ID_BITS    = sktl_pkg::ID_BITS_DEF,
  parameter int KEY_BITS   = sktl_pkg::KEY_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [sktl_pkg::REQ_BITS-1:0]   req_type,
  input  logic [ID_BITS-1:0]              tile_id,
  input  logic [KEY_BITS-1:0]             sort_key,
  input  logic [sktl_pkg::DIR_BITS-1:0]   direction,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            hit,
  output logic                            dropped,
  output logic [sktl_pkg::COUNT_BITS-1:0] entry_count
);

  import sktl_pkg::*;

  localparam int IDX_W = $clog2(LIST_DEPTH);
  localparam int CNT_W = $clog2(LIST_DEPTH + 1);
  localparam int ENT_W = ID_BITS + KEY_BITS + DIR_BITS;

  state_t               state;
  logic                 pend;
  logic [CNT_W-1:0]     count;
  logic [CNT_W-1:0]     idx;
  logic [CNT_W-1:0]     ins;
  req_t                 req;
  logic [ID_BITS-1:0]   id_q;
  logic [KEY_BITS-1:0]  key_q;
  logic [DIR_BITS-1:0]  dir_q;
  logic                 hit_w;
  logic                 drop_w;

  logic [CNT_W-1:0]     idx_inc;
  logic [CNT_W-1:0]     idx_dec;
  logic                 full;
  logic                 rd_en;
  logic [IDX_W-1:0]     rd_addr;
  logic [ENT_W-1:0]     rd_data;
  logic                 wr_en;
  logic [IDX_W-1:0]     wr_addr;
  logic [ENT_W-1:0]     wr_data;
  logic [ID_BITS-1:0]   rd_id;
  logic [KEY_BITS-1:0]  rd_key;
  logic                 out_free;
  logic [CNT_W+COUNT_BITS-1:0] cnt_ext;

  assign idx_inc  = idx + CNT_W'(1);
  assign idx_dec  = idx - CNT_W'(1);
  assign full     = (count == CNT_W'(LIST_DEPTH));
  assign rd_id    = rd_data[ENT_W-1 -: ID_BITS];
  assign rd_key   = rd_data[DIR_BITS +: KEY_BITS];
  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != ST_IDLE);
  assign cnt_ext  = (CNT_W + COUNT_BITS)'(count);

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = idx[IDX_W-1:0];
    wr_en   = 1'b0;
    wr_addr = idx[IDX_W-1:0];
    wr_data = rd_data;
    unique case (state)
      ST_FIND, ST_SEEK: begin
        rd_en = !pend;
      end
      ST_DEL: begin
        rd_en   = !pend;
        rd_addr = idx_inc[IDX_W-1:0];
        wr_en   = pend;
      end
      ST_INS: begin
        rd_en   = !pend;
        rd_addr = idx_dec[IDX_W-1:0];
        wr_en   = pend;
      end
      ST_PUT: begin
        wr_en   = 1'b1;
        wr_data = {id_q, key_q, dir_q};
      end
      default: begin
      end
    endcase
  end

  sktl_ram #(
    .WIDTH(ENT_W),
    .DEPTH(LIST_DEPTH)
  ) u_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      pend      <= 1'b0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (state == ST_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            req    <= req_t'(req_type);
            id_q   <= tile_id;
            key_q  <= sort_key;
            dir_q  <= direction;
            hit_w  <= 1'b0;
            drop_w <= 1'b0;
            idx    <= '0;
            pend   <= 1'b0;
            if (req_type == REQ_ADD || req_type == REQ_REMOVE || req_type == REQ_QUERY) begin
              state <= ST_FIND;
            end else begin
              state <= ST_DONE;
            end
          end
        end
        ST_FIND: begin
          if (!pend) begin
            if (idx == count) begin
              // id absent
              if (req == REQ_ADD) begin
                if (full) begin
                  drop_w <= 1'b1;
                  state  <= ST_DONE;
                end else begin
                  idx   <= '0;
                  state <= ST_SEEK;
                end
              end else begin
                state <= ST_DONE;
              end
            end else begin
              pend <= 1'b1;
            end
          end else begin
            pend <= 1'b0;
            if (rd_id == id_q) begin
              hit_w <= 1'b1;
              if (req == REQ_QUERY) begin
                state <= ST_DONE;
              end else begin
                state <= ST_DEL;
              end
            end else begin
              idx <= idx_inc;
            end
          end
        end
        ST_DEL: begin
          if (!pend) begin
            if (idx_inc >= count) begin
              count <= count - CNT_W'(1);
              idx   <= '0;
              if (req == REQ_ADD) begin
                state <= ST_SEEK;
              end else begin
                state <= ST_DONE;
              end
            end else begin
              pend <= 1'b1;
            end
          end else begin
            pend <= 1'b0;
            idx  <= idx_inc;
          end
        end
        ST_SEEK: begin
          if (!pend) begin
            if (idx == count) begin
              ins   <= idx;
              state <= ST_INS;
            end else begin
              pend <= 1'b1;
            end
          end else begin
            pend <= 1'b0;
            if (rd_key <= key_q) begin
              idx <= idx_inc;
            end else begin
              ins   <= idx;
              idx   <= count;
              state <= ST_INS;
            end
          end
        end
        ST_INS: begin
          if (!pend) begin
            if (idx == ins) begin
              state <= ST_PUT;
            end else begin
              pend <= 1'b1;
            end
          end else begin
            pend <= 1'b0;
            idx  <= idx_dec;
          end
        end
        ST_PUT: begin
          count <= count + CNT_W'(1);
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (out_free) begin
            hit         <= hit_w;
            dropped     <= drop_w;
            entry_count <= cnt_ext[COUNT_BITS-1:0];
            state       <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

@@ rtl/core/sktl_ram.sv @@
module sktl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
